// ===== rtl/msb_pkg.sv =====
// Shared types and codes for the multi-stack bank.
package msb_pkg;

  localparam int DW  = 32;
  localparam int OPW = 3;
  localparam int SSW = 4;
  localparam int STW = 3;

  localparam logic [OPW-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPW-1:0] OP_POP   = 3'd1;
  localparam logic [OPW-1:0] OP_PEEK  = 3'd2;
  localparam logic [OPW-1:0] OP_EMPTY = 3'd3;
  localparam logic [OPW-1:0] OP_ADD   = 3'd4;
  localparam logic [OPW-1:0] OP_FIND  = 3'd5;
  localparam logic [OPW-1:0] OP_CLEAR = 3'd6;
  localparam logic [OPW-1:0] OP_NONE  = 3'd7;

  localparam logic [STW-1:0] ST_OK         = 3'd0;
  localparam logic [STW-1:0] ST_BAD_STACK  = 3'd1;
  localparam logic [STW-1:0] ST_OVERFLOW   = 3'd2;
  localparam logic [STW-1:0] ST_UNDERFLOW  = 3'd3;
  localparam logic [STW-1:0] ST_EMPTY_PEEK = 3'd4;

  localparam logic [DW-1:0] MARKER = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OPW-1:0]       req_type;
    logic [SSW-1:0]       stack_sel;
    logic signed [DW-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] read_value;
    logic                 flag;
    logic [STW-1:0]       status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT,
    S_SCAN
  } state_t;

endpackage

// ===== rtl/msb_ram.sv =====
// Generic single-port RAM with registered read data.
module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/multi_stack_bank.sv =====
// Top level of the multi-stack bank: request decode, stack pointers and entry RAM.
//
// A bank of STACK_COUNT integer stacks, each STACK_DEPTH entries deep, held
// in one single-port RAM. A request transaction (in_data: req_type,
// stack_sel, operand) is taken at a rising edge with start high and busy
// low. Exactly one result transaction per request appears on out_data,
// marked by out_valid for a single cycle; the receiver cannot stall it.
// push, is_empty, errors, no-op and trivial clear are answered from the
// decode state; pop, peek and add_to_top wait for one RAM read (then write
// back for add); find and clear_to_marker do one RAM read per cycle
// walking down from the top.
// busy is high from acceptance until the cycle the result is registered;
// a new request may be accepted while out_valid is high.
// Stack pointers sit in flip-flops; synchronous reset (rst_n low) empties
// every stack at once. Entry RAM contents are not cleared; no request reads
// an entry above its stack's top.
module multi_stack_bank #(
  parameter int STACK_COUNT = 8,
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  msb_pkg::req_t in_data,
  output logic          out_valid,
  output msb_pkg::rsp_t out_data
);

  import msb_pkg::*;

  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int PW    = $clog2(STACK_DEPTH);
  localparam int SELW  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int RAM_D = STACK_COUNT * STACK_DEPTH;
  localparam int AW    = (RAM_D > 1) ? $clog2(RAM_D) : 1;

  state_t         state_r, state_nxt;
  req_t           req_r;
  logic [CW-1:0]  count_r [STACK_COUNT];
  logic [CW-1:0]  count_nxt;
  logic           cnt_we;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           out_valid_r;
  rsp_t           out_data_r;
  rsp_t           rsp;
  logic           emit;

  logic [SELW-1:0] sel_idx;
  logic            sel_ok;
  logic [CW-1:0]   cur_cnt;
  logic            empty;
  logic [PW-1:0]   top_pos;
  logic [AW-1:0]   base;

  logic            ram_en;
  logic            ram_we;
  logic [PW-1:0]   ram_pos;
  logic [AW-1:0]   ram_addr;
  logic [DW-1:0]   ram_wdata;
  logic [DW-1:0]   ram_rdata;

  assign sel_idx = req_r.stack_sel[SELW-1:0];
  assign sel_ok  = ({1'b0, req_r.stack_sel} < (SSW+1)'(STACK_COUNT));
  assign cur_cnt = count_r[sel_idx];
  assign empty   = (cur_cnt == '0);
  assign top_pos = PW'(cur_cnt - CW'(1));
  assign base    = AW'(sel_idx * STACK_DEPTH);
  assign ram_addr = base + AW'(ram_pos);

  msb_ram #(
    .WIDTH(DW),
    .DEPTH(RAM_D)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    count_nxt = cur_cnt;
    cnt_we    = 1'b0;
    emit      = 1'b0;
    rsp       = '0;
    rsp.status = ST_OK;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_pos   = pos_r;
    ram_wdata = req_r.operand;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (req_r.req_type == OP_NONE) begin
          emit = 1'b1;
        end else if (!sel_ok) begin
          rsp.status = ST_BAD_STACK;
          emit = 1'b1;
        end else begin
          case (req_r.req_type)
            OP_PUSH: begin
              if (cur_cnt == CW'(STACK_DEPTH)) begin
                rsp.status = ST_OVERFLOW;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_pos   = PW'(cur_cnt);
                cnt_we    = 1'b1;
                count_nxt = cur_cnt + CW'(1);
              end
              emit = 1'b1;
            end
            OP_POP, OP_PEEK, OP_ADD: begin
              if (empty) begin
                rsp.status = (req_r.req_type == OP_PEEK) ? ST_EMPTY_PEEK : ST_UNDERFLOW;
                emit = 1'b1;
              end else begin
                ram_en    = 1'b1;
                ram_pos   = top_pos;
                pos_nxt   = top_pos;
                state_nxt = S_WAIT;
              end
            end
            OP_EMPTY: begin
              rsp.flag = empty;
              emit = 1'b1;
            end
            OP_FIND: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                ram_en    = 1'b1;
                ram_pos   = top_pos;
                pos_nxt   = top_pos;
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              if (empty) begin
                emit = 1'b1;
              end else if (cur_cnt == CW'(1)) begin
                cnt_we    = 1'b1;
                count_nxt = '0;
                emit      = 1'b1;
              end else begin
                ram_en    = 1'b1;
                ram_pos   = top_pos;
                pos_nxt   = top_pos;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_WAIT: begin
        case (req_r.req_type)
          OP_POP: begin
            rsp.read_value = $signed(ram_rdata);
            cnt_we    = 1'b1;
            count_nxt = cur_cnt - CW'(1);
          end
          OP_PEEK: begin
            rsp.read_value = $signed(ram_rdata);
          end
          default: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = ram_rdata + $unsigned(req_r.operand);
          end
        endcase
        emit = 1'b1;
      end

      S_SCAN: begin
        if (req_r.req_type == OP_FIND) begin
          if (ram_rdata == $unsigned(req_r.operand)) begin
            rsp.flag = 1'b1;
            emit = 1'b1;
          end else if (pos_r == '0) begin
            emit = 1'b1;
          end else begin
            ram_en  = 1'b1;
            ram_pos = pos_r - PW'(1);
            pos_nxt = pos_r - PW'(1);
          end
        end else begin
          if (ram_rdata == MARKER) begin
            cnt_we    = 1'b1;
            count_nxt = CW'(pos_r);
            emit      = 1'b1;
          end else if (pos_r == PW'(1)) begin
            cnt_we    = 1'b1;
            count_nxt = '0;
            emit      = 1'b1;
          end else begin
            ram_en  = 1'b1;
            ram_pos = pos_r - PW'(1);
            pos_nxt = pos_r - PW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STACK_COUNT; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (cnt_we) begin
        count_r[sel_idx] <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
    pos_r <= pos_nxt;
    if (emit) begin
      out_data_r <= rsp;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/msb_checker.sv =====
// Port-level checks for the multi-stack bank, bound to the top level.
module msb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input msb_pkg::rsp_t out_data
);

  import msb_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in flight");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("still busy while result is shown");

  a_bad_stack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_BAD_STACK) |->
      (!out_data.flag && out_data.read_value == '0))
    else $error("bad stack result carries data");

  a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.flag) |-> (out_data.status == ST_OK))
    else $error("flag set on an error result");

endmodule

bind multi_stack_bank msb_checker u_msb_checker (.*);

// ===== bench/tb_multi_stack_bank.sv =====
// Testbench for multi_stack_bank: directed and random requests checked against a shadow model.
`timescale 1ns / 100ps

module tb_multi_stack_bank;
  import msb_pkg::*;

  localparam int NSTK  = 8;
  localparam int DEPTH = 64;

  class stack_shadow;
    int             top_idx [NSTK];
    logic [DW-1:0]  entries [NSTK][DEPTH];
    rsp_t           pending_rsp [$];
    int             errors;

    function new();
      foreach (top_idx[s]) top_idx[s] = -1;
      errors = 0;
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction

    // Predict the response of one accepted request and update the shadow stacks.
    function void take_request(req_t r);
      rsp_t e;
      int   s;
      int   t;
      int   i;
      e = '0;
      s = int'(r.stack_sel);
      if (r.req_type == OP_NONE) begin
      end else if (s >= NSTK) begin
        e.status = ST_BAD_STACK;
      end else begin
        t = top_idx[s];
        case (r.req_type)
          OP_PUSH: begin
            if (t + 1 >= DEPTH) e.status = ST_OVERFLOW;
            else begin
              top_idx[s] = t + 1;
              entries[s][t + 1] = r.operand;
            end
          end
          OP_POP: begin
            if (t < 0) e.status = ST_UNDERFLOW;
            else begin
              e.read_value = entries[s][t];
              top_idx[s] = t - 1;
            end
          end
          OP_PEEK: begin
            if (t < 0) e.status = ST_EMPTY_PEEK;
            else e.read_value = entries[s][t];
          end
          OP_EMPTY: e.flag = (t < 0);
          OP_ADD: begin
            if (t < 0) e.status = ST_UNDERFLOW;
            else entries[s][t] = entries[s][t] + r.operand;
          end
          OP_FIND: begin
            for (i = t; i >= 0; i--) begin
              if (entries[s][i] == r.operand) begin
                e.flag = 1'b1;
                break;
              end
            end
          end
          default: begin
            // clear down to the marker; entry 0 is never examined
            if (t >= 0) begin
              for (i = t; i > 0; i--) begin
                if (entries[s][i] == MARKER) break;
              end
              top_idx[s] = i - 1;
            end
          end
        endcase
      end
      pending_rsp.push_back(e);
    endfunction

    function void match_response(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: read_value %0h flag %0b status %0d",
               got.read_value, got.flag, got.status);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.read_value !== e.read_value) begin
        $error("read_value: expected %0h, got %0h", e.read_value, got.read_value);
        errors++;
      end
      if (got.flag !== e.flag) begin
        $error("flag: expected %0b, got %0b", e.flag, got.flag);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_data = '0;
  logic out_valid;
  rsp_t out_data;

  stack_shadow shadow = new();

  int burst_left = 0;

  multi_stack_bank #(
    .STACK_COUNT(NSTK),
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.match_response(out_data);
      if (start && !busy) shadow.take_request(in_data);
    end
  end

  task automatic issue(input logic [OPW-1:0] op, input int sel, input logic [DW-1:0] val);
    req_t r;
    r.req_type  = op;
    r.stack_sel = sel[SSW-1:0];
    r.operand   = val;
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4:          return MARKER;
      5:          return 32'h7FFF_FFFF;
      6:          return 32'h8000_0000;
      default:    return $urandom;
    endcase
  endfunction

  // Bursty sender: random-length bursts with random gaps unless gapless.
  task automatic random_phase(input int count, input int push_pct, input int focus,
                              input bit gapless);
    logic [OPW-1:0] op;
    int             sel;
    int             k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
      else if ($urandom_range(0, 49) == 0) op = OP_NONE;
      else op = OPW'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) sel = $urandom_range(NSTK, 15);
      else if (focus >= 0 && $urandom_range(0, 3) != 0) sel = focus;
      else sel = $urandom_range(0, NSTK - 1);
      if (!gapless && burst_left == 0) begin
        idle($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end
      issue(op, sel, pick_operand());
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_EMPTY, 0, 32'd0);
    issue(OP_POP,   0, 32'd0);
    issue(OP_PEEK,  0, 32'd0);
    issue(OP_ADD,   0, 32'd3);
    issue(OP_CLEAR, 0, 32'd0);
    issue(OP_FIND,  0, 32'd0);
    issue(OP_NONE, 15, 32'hFFFF_FFFF);
    for (k = 0; k < 7; k++) issue(k[OPW-1:0], (k % 2) ? 8 : 15, 32'hFFFF_FFFF);
    issue(OP_PUSH,  7, 32'h7FFF_FFFF);
    issue(OP_ADD,   7, 32'd1);
    issue(OP_PEEK,  7, 32'd0);
    issue(OP_PUSH,  7, MARKER);
    issue(OP_PUSH,  7, 32'h8000_0000);
    issue(OP_FIND,  7, 32'h7FFF_FFFF);
    issue(OP_FIND,  7, MARKER);
    issue(OP_CLEAR, 7, 32'd0);
    issue(OP_PUSH,  7, 32'd5);
    issue(OP_CLEAR, 7, 32'd0);
    issue(OP_EMPTY, 7, 32'd0);
    issue(OP_POP,   7, 32'd0);

    // hold off until the bank has answered everything
    drain();

    random_phase(200, 85, 3, 1'b0);
    random_phase(150, 50, -1, 1'b1);
    drain();
    random_phase(200, 35, 3, 1'b0);
    random_phase(150, 55, 5, 1'b0);
    random_phase(100, 20, -1, 1'b1);

    drain();
    repeat (80) @(posedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("tb_multi_stack_bank: done, clean");
    end else begin
      $display("tb_multi_stack_bank: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_multi_stack_bank: done, errors");
    $finish;
  end

endmodule
